>>> sv/lcb_pkg.sv
// Shared types and constants for the Luhn card brand checker.
package lcb_pkg;

    localparam int IN_WIDTH   = 63;
    localparam int NUM_CELLS  = 19;
    localparam int MAX_DIGITS = 19;

    localparam int DIGIT_W = 4;
    localparam int CNT_W   = $clog2(IN_WIDTH);
    localparam int IDX_W   = $clog2(NUM_CELLS);
    localparam int COUNT_W = 5;
    localparam int BRAND_W = 2;

    localparam logic [COUNT_W-1:0] LEN_13 = COUNT_W'(13);
    localparam logic [COUNT_W-1:0] LEN_15 = COUNT_W'(15);
    localparam logic [COUNT_W-1:0] LEN_16 = COUNT_W'(16);

    typedef enum logic [BRAND_W-1:0] {
        BRAND_NONE = 2'd0,
        BRAND_3X   = 2'd1,
        BRAND_5X   = 2'd2,
        BRAND_4X   = 2'd3
    } t_brand;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_CONV = 2'd1,
        S_SCAN = 2'd2,
        S_FIN  = 2'd3
    } t_state;

    typedef struct packed {
        logic clear;
        logic bit_shift;
        logic dig_shift;
    } t_cell_ctl;

    typedef struct packed {
        logic clear;
        logic en;
    } t_scan_ctl;

    typedef struct packed {
        logic [DIGIT_W-1:0] sum_mod;
        logic [COUNT_W-1:0] count;
        logic [DIGIT_W-1:0] lead_hi;
        logic [DIGIT_W-1:0] lead_lo;
    } t_scan_res;

endpackage

>>> sv/luhn_card_brand_check.sv
// Top level: Luhn check and brand pick for a binary card number.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------
//  in      | to block  | i_in_valid / o_in_stall    | i_card_number[62:0]
//  out     | from block| o_out_valid / i_out_stall  | o_brand, o_luhn_ok, o_digit_count
//
// Each word goes through binary to BCD conversion (one input bit per cycle
// through the digit cells), digit scan (one digit per cycle out of the
// bottom cell) and classify; a new word is taken only once the last one
// has been classified. The result register is loaded by classify; if it
// still holds an untaken word, classify waits there.
// Reset (synchronous, active low) clears the sequencer and the result valid.
module luhn_card_brand_check (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [lcb_pkg::IN_WIDTH-1:0] i_card_number,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [lcb_pkg::BRAND_W-1:0]  o_brand,
    output logic                         o_luhn_ok,
    output logic [lcb_pkg::COUNT_W-1:0]  o_digit_count
);
    import lcb_pkg::*;

    t_state r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [IN_WIDTH-1:0] r_shift, n_shift;

    logic                r_out_valid, n_out_valid;
    logic [BRAND_W-1:0]  r_brand, n_brand;
    logic                r_luhn_ok, n_luhn_ok;
    logic [COUNT_W-1:0]  r_count, n_count;

    t_cell_ctl cell_ctl;
    t_scan_ctl scan_ctl;
    t_scan_res scan_res;

    logic                in_acc;
    logic                out_free;
    logic                ok;
    t_brand              brand;

    logic [NUM_CELLS-1:0] cell_bit_in;
    logic [NUM_CELLS-1:0] cell_bit_out;
    logic [DIGIT_W-1:0]   cell_dig_in  [NUM_CELLS];
    logic [DIGIT_W-1:0]   cell_dig_out [NUM_CELLS];

    // Row of BCD cells. Bits climb from cell 0 upward during conversion;
    // digits drop toward cell 0 during the scan, least significant first.
    genvar g;
    generate
        for (g = 0; g < NUM_CELLS; g++) begin : g_cell
            if (g == 0) begin : g_low
                assign cell_bit_in[g] = r_shift[IN_WIDTH-1];
            end else begin : g_mid
                assign cell_bit_in[g] = cell_bit_out[g-1];
            end
            if (g == NUM_CELLS-1) begin : g_top
                assign cell_dig_in[g] = '0;
            end else begin : g_below
                assign cell_dig_in[g] = cell_dig_out[g+1];
            end
            lcb_digit_cell u_cell (
                .i_clk (i_clk),
                .i_ctl (cell_ctl),
                .i_bit (cell_bit_in[g]),
                .i_dig (cell_dig_in[g]),
                .o_bit (cell_bit_out[g]),
                .o_dig (cell_dig_out[g])
            );
        end
    endgenerate

    // Consume the digit stream coming out of the bottom cell.
    lcb_digit_scan u_scan (
        .i_clk   (i_clk),
        .i_ctl   (scan_ctl),
        .i_digit (cell_dig_out[0]),
        .i_idx   (r_idx),
        .o_res   (scan_res)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Classify: Luhn verdict from the sum and the count, brand from the count and the two leading digits.
    always_comb begin
        ok    = (scan_res.sum_mod == '0) && (scan_res.count <= COUNT_W'(MAX_DIGITS));
        brand = BRAND_NONE;
        if (ok) begin
            if (scan_res.count == LEN_13) begin
                if (scan_res.lead_hi == DIGIT_W'(4)) begin
                    brand = BRAND_4X;
                end
            end else if (scan_res.count == LEN_15) begin
                if (scan_res.lead_hi == DIGIT_W'(3) &&
                    (scan_res.lead_lo == DIGIT_W'(4) || scan_res.lead_lo == DIGIT_W'(7))) begin
                    brand = BRAND_3X;
                end
            end else if (scan_res.count == LEN_16) begin
                if (scan_res.lead_hi == DIGIT_W'(5) && scan_res.lead_lo >= DIGIT_W'(1) &&
                    scan_res.lead_lo <= DIGIT_W'(5)) begin
                    brand = BRAND_5X;
                end else if (scan_res.lead_hi == DIGIT_W'(4)) begin
                    brand = BRAND_4X;
                end
            end
        end
    end

    // Sequencer: next state, cell and scan controls, result register load.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_shift     = r_shift;
        n_out_valid = r_out_valid;
        n_brand     = r_brand;
        n_luhn_ok   = r_luhn_ok;
        n_count     = r_count;
        cell_ctl    = '0;
        scan_ctl    = '0;

        // drop the result word once it is taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_shift        = i_card_number;
                    n_cnt          = '0;
                    cell_ctl.clear = 1'b1;
                    scan_ctl.clear = 1'b1;
                    n_state        = S_CONV;
                end
            end
            S_CONV: begin
                // advance one bit, MSB first
                cell_ctl.bit_shift = 1'b1;
                n_shift            = {r_shift[IN_WIDTH-2:0], 1'b0};
                n_cnt              = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(IN_WIDTH-1)) begin
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                cell_ctl.dig_shift = 1'b1;
                scan_ctl.en        = 1'b1;
                n_idx              = r_idx + IDX_W'(1);
                if (r_idx == IDX_W'(NUM_CELLS-1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the result register is free
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_brand     = brand;
                    n_luhn_ok   = ok;
                    n_count     = scan_res.count;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_idx     <= n_idx;
        r_shift   <= n_shift;
        r_brand   <= n_brand;
        r_luhn_ok <= n_luhn_ok;
        r_count   <= n_count;
    end

    assign o_out_valid   = r_out_valid;
    assign o_brand       = r_brand;
    assign o_luhn_ok     = r_luhn_ok;
    assign o_digit_count = r_count;

`ifndef SYNTHESIS
    a_acc_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == S_CONV)
        else $error("accepted word did not start conversion");

    a_conv_to_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV && r_cnt == CNT_W'(IN_WIDTH-1)) |=> r_state == S_SCAN)
        else $error("conversion did not hand over to scan");

    a_load_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_FIN)
        else $error("result loaded outside classify");

    a_brand_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_brand != BRAND_NONE) |-> o_luhn_ok)
        else $error("brand given without passing check");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_digit_count <= COUNT_W'(NUM_CELLS))
        else $error("digit count out of range");
`endif

endmodule

>>> sv/lcb_digit_cell.sv
// One BCD digit cell: double-dabble bit shift upward, digit shift downward.
module lcb_digit_cell (
    input  logic                      i_clk,
    input  lcb_pkg::t_cell_ctl        i_ctl,
    input  logic                      i_bit,
    input  logic [lcb_pkg::DIGIT_W-1:0] i_dig,
    output logic                      o_bit,
    output logic [lcb_pkg::DIGIT_W-1:0] o_dig
);
    import lcb_pkg::*;

    logic [DIGIT_W-1:0] r_dig;
    logic [DIGIT_W-1:0] n_dig;
    logic [DIGIT_W-1:0] adj;

    // add 3 before the shift so the digit carries out at ten
    assign adj   = (r_dig >= DIGIT_W'(5)) ? r_dig + DIGIT_W'(3) : r_dig;
    assign o_bit = adj[DIGIT_W-1];
    assign o_dig = r_dig;

    always_comb begin
        n_dig = r_dig;
        if (i_ctl.clear) begin
            n_dig = '0;
        end else if (i_ctl.bit_shift) begin
            n_dig = {adj[DIGIT_W-2:0], i_bit};
        end else if (i_ctl.dig_shift) begin
            n_dig = i_dig;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dig <= n_dig;
    end

endmodule

>>> sv/lcb_digit_scan.sv
// Digit stream accumulator: Luhn sum mod ten, digit count, two leading digits.
module lcb_digit_scan (
    input  logic                        i_clk,
    input  lcb_pkg::t_scan_ctl          i_ctl,
    input  logic [lcb_pkg::DIGIT_W-1:0] i_digit,
    input  logic [lcb_pkg::IDX_W-1:0]   i_idx,
    output lcb_pkg::t_scan_res          o_res
);
    import lcb_pkg::*;

    logic [DIGIT_W-1:0] r_sum_mod, n_sum_mod;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [DIGIT_W-1:0] r_lead_hi, n_lead_hi;
    logic [DIGIT_W-1:0] r_lead_lo, n_lead_lo;
    logic [DIGIT_W-1:0] r_prev, n_prev;
    logic [DIGIT_W:0]   dbl;
    logic [DIGIT_W-1:0] term;
    logic [DIGIT_W:0]   sum;

    always_comb begin
        // odd positions from the right are doubled
        dbl  = {i_digit, 1'b0};
        term = i_digit;
        if (i_idx[0]) begin
            term = (dbl >= (DIGIT_W+1)'(10)) ? DIGIT_W'(dbl - (DIGIT_W+1)'(9))
                                              : DIGIT_W'(dbl);
        end
        sum = {1'b0, r_sum_mod} + {1'b0, term};
        if (sum >= (DIGIT_W+1)'(10)) begin
            sum = sum - (DIGIT_W+1)'(10);
        end

        n_sum_mod = r_sum_mod;
        n_count   = r_count;
        n_lead_hi = r_lead_hi;
        n_lead_lo = r_lead_lo;
        n_prev    = r_prev;
        if (i_ctl.clear) begin
            n_sum_mod = '0;
            n_count   = '0;
            n_lead_hi = '0;
            n_lead_lo = '0;
            n_prev    = '0;
        end else if (i_ctl.en) begin
            n_sum_mod = sum[DIGIT_W-1:0];
            n_prev    = i_digit;
            if (i_digit != '0) begin
                n_count   = COUNT_W'(i_idx) + COUNT_W'(1);
                n_lead_hi = i_digit;
                n_lead_lo = r_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum_mod <= n_sum_mod;
        r_count   <= n_count;
        r_lead_hi <= n_lead_hi;
        r_lead_lo <= n_lead_lo;
        r_prev    <= n_prev;
    end

    assign o_res = '{sum_mod: r_sum_mod, count: r_count,
                     lead_hi: r_lead_hi, lead_lo: r_lead_lo};

endmodule

>>> tb/sv/tb_luhn_card_brand_check.sv
// Self-checking testbench for the Luhn card brand checker: random and directed card numbers.
`timescale 1ns / 100ps

module tb_luhn_card_brand_check;

    import lcb_pkg::*;

    // Verdict the block must return for one card number.
    typedef struct packed {
        t_brand             brand;
        logic               luhn_ok;
        logic [COUNT_W-1:0] digit_count;
    } t_verdict;

    // One card number waiting to be offered, with the idle cycles ahead of it.
    // A hold_back word is not offered until every earlier verdict has come back.
    typedef struct {
        logic [IN_WIDTH-1:0] number;
        int unsigned         gap;
        bit                  hold_back;
    } t_card_word;

    localparam int unsigned HOLD_OFF_CYCLES = 800;  // long output stall, fills the block
    localparam int unsigned HOLD_OFF_AT     = 200;  // results taken before the stall
    localparam int unsigned TAIL_CYCLES     = 200;  // quiet time after the last verdict
    localparam int unsigned RANDOM_WORDS    = 1400;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [IN_WIDTH-1:0]  i_card_number = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [BRAND_W-1:0]   o_brand;
    logic                 o_luhn_ok;
    logic [COUNT_W-1:0]   o_digit_count;

    t_card_word  cards_pending[$];
    t_verdict    verdicts_due[$];

    int unsigned wait_left = 0;
    int unsigned words_accepted = 0;
    int unsigned results_taken = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned faults = 0;
    int unsigned luhn_passes = 0;
    int unsigned brand_tally[4] = '{0, 0, 0, 0};

    luhn_card_brand_check u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_card_number (i_card_number),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_brand       (o_brand),
        .o_luhn_ok     (o_luhn_ok),
        .o_digit_count (o_digit_count)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Walk the decimal digits from the right, doubling every second one, and
    // return the Luhn total along with the digit count.
    function automatic void luhn_digits(input logic [IN_WIDTH-1:0] num,
                                        output int unsigned total,
                                        output int unsigned ndig);
        bit [63:0]   rest;
        int unsigned d;
        bit          twice;
        rest  = {1'b0, num};
        total = 0;
        ndig  = 0;
        twice = 1'b0;
        while (rest != 0) begin
            d    = rest % 64'd10;
            rest = rest / 64'd10;
            if (twice) begin
                d = d * 2;
                if (d >= 10)
                    d = d - 9;
            end
            total += d;
            twice = !twice;
            ndig++;
        end
    endfunction

    // Predict the verdict: Luhn result, digit count, then the brand pick on
    // length and leading digits, only when the Luhn check passed.
    function automatic t_verdict card_verdict(input logic [IN_WIDTH-1:0] num);
        t_verdict    v;
        int unsigned total;
        int unsigned ndig;
        bit [63:0]   n;
        bit [63:0]   lead;
        n = {1'b0, num};
        luhn_digits(num, total, ndig);
        v.brand       = BRAND_NONE;
        v.luhn_ok     = (total % 10 == 0) && (ndig <= MAX_DIGITS);
        v.digit_count = COUNT_W'(ndig);
        if (v.luhn_ok) begin
            case (COUNT_W'(ndig))
                LEN_13: begin
                    if (n / 64'd1000000000000 == 64'd4)
                        v.brand = BRAND_4X;
                end
                LEN_15: begin
                    lead = n / 64'd10000000000000;
                    if (lead == 64'd34 || lead == 64'd37)
                        v.brand = BRAND_3X;
                end
                LEN_16: begin
                    lead = n / 64'd100000000000000;
                    if (lead >= 64'd51 && lead <= 64'd55)
                        v.brand = BRAND_5X;
                    else if (n / 64'd1000000000000000 == 64'd4)
                        v.brand = BRAND_4X;
                end
                default: ;
            endcase
        end
        return v;
    endfunction

    // Build a number of ndig digits that starts with lead (one or two digits),
    // random in the middle, with a check digit that makes the Luhn sum right
    // or, when luhn_good is clear, deliberately wrong.
    function automatic logic [IN_WIDTH-1:0] make_card(input int unsigned lead,
                                                      input int unsigned ndig,
                                                      input bit luhn_good);
        bit [63:0]   body;
        int unsigned lead_len;
        int unsigned total;
        int unsigned cnt;
        int unsigned chk;
        body     = lead;
        lead_len = (lead >= 10) ? 2 : 1;
        for (int unsigned i = lead_len; i + 1 < ndig; i++)
            body = body * 10 + $urandom_range(0, 9);
        body = body * 10;
        luhn_digits(body[IN_WIDTH-1:0], total, cnt);
        chk = (10 - total % 10) % 10;
        if (!luhn_good)
            chk = (chk + 1 + $urandom_range(0, 8)) % 10;
        return body[IN_WIDTH-1:0] + IN_WIDTH'(chk);
    endfunction

    // Random raw word: all 63 bits random, then shifted down to vary the length.
    function automatic logic [IN_WIDTH-1:0] raw_card();
        logic [IN_WIDTH-1:0] w;
        w = {$urandom, $urandom};
        return w >> $urandom_range(0, IN_WIDTH - 1);
    endfunction

    // Append a word; the sender runs without gaps on every third block of 100.
    task automatic queue_card(input logic [IN_WIDTH-1:0] num, input bit hold_back);
        t_card_word w;
        w.number    = num;
        w.gap       = ((cards_pending.size() / 100) % 3 == 2) ? 0 : $urandom_range(0, 9);
        w.hold_back = hold_back;
        cards_pending.push_back(w);
    endtask

    // Pick one of the brand-shaped patterns: 34/37 at 15, 51-55 at 16, 4 at 13 or 16.
    function automatic logic [IN_WIDTH-1:0] brand_card(input bit luhn_good);
        case ($urandom_range(0, 3))
            0:       return make_card($urandom_range(0, 1) ? 34 : 37, 15, luhn_good);
            1:       return make_card($urandom_range(51, 55), 16, luhn_good);
            2:       return make_card(4, 13, luhn_good);
            default: return make_card(4, 16, luhn_good);
        endcase
    endfunction

    // Driver: offer words from the pending queue; hold the word while stalled,
    // advance straight to the next one when no gap is drawn.
    always @(posedge i_clk) begin : drive
        bit took;
        took = i_in_valid && !o_in_stall;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            wait_left  <= 0;
        end else begin
            if (took) begin
                verdicts_due.push_back(card_verdict(i_card_number));
                words_accepted <= words_accepted + 1;
            end
            if (took || !i_in_valid) begin
                if (wait_left != 0) begin
                    wait_left  <= wait_left - 1;
                    i_in_valid <= 1'b0;
                end else if (cards_pending.size() != 0 &&
                             !(cards_pending[0].hold_back &&
                               (took || words_accepted != results_taken))) begin
                    i_card_number <= cards_pending[0].number;
                    i_in_valid    <= 1'b1;
                    wait_left     <= (cards_pending.size() > 1) ? cards_pending[1].gap : 0;
                    void'(cards_pending.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long output hold-off, counted on its own: once the first few hundred
    // verdicts are in, stall the output long enough for the block to back up
    // and stall its input while the driver keeps offering.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_taken == HOLD_OFF_AT) begin
            hold_left <= HOLD_OFF_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Monitor: take verdicts, compare against the oldest prediction, and draw
    // the stall for the next verdict. Stall cycles count down only while a
    // verdict is on offer, so they land on it; every third block of 128
    // verdicts runs without stalls.
    always @(posedge i_clk) begin : watch
        t_verdict    want;
        int unsigned nxt;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else begin
            nxt = stall_left;
            if (o_out_valid && !i_out_stall) begin
                results_taken <= results_taken + 1;
                if (verdicts_due.size() == 0) begin
                    faults++;
                    if (faults <= 10)
                        $display("%0t: unexpected verdict brand %0d luhn_ok %0b digits %0d",
                                 $realtime, o_brand, o_luhn_ok, o_digit_count);
                end else begin
                    want = verdicts_due.pop_front();
                    if (o_brand !== want.brand || o_luhn_ok !== want.luhn_ok ||
                        o_digit_count !== want.digit_count) begin
                        faults++;
                        if (faults <= 10) begin
                            $display("%0t: verdict %0d mismatch", $realtime, results_taken);
                            $display("  brand exp %0d got %0d, luhn_ok exp %0b got %0b",
                                     want.brand, o_brand, want.luhn_ok, o_luhn_ok);
                            $display("  digits exp %0d got %0d",
                                     want.digit_count, o_digit_count);
                        end
                    end
                    if (want.luhn_ok)
                        luhn_passes++;
                    brand_tally[int'(want.brand)]++;
                end
                nxt = ((results_taken / 128) % 3 == 1) ? 0 : $urandom_range(0, 9);
            end else if (o_out_valid && nxt != 0) begin
                nxt--;
            end
            stall_left  <= nxt;
            i_out_stall <= (hold_left != 0) || (nxt != 0);
        end
    end

    initial begin
        // Directed: zero, tiny and full-width numbers, each brand pattern with
        // good and bad check digits, and near misses on length and prefix.
        queue_card('0, 1'b0);
        queue_card(IN_WIDTH'(1), 1'b0);
        queue_card(IN_WIDTH'(18), 1'b0);
        queue_card({IN_WIDTH{1'b1}}, 1'b0);
        queue_card({1'b1, {(IN_WIDTH-1){1'b0}}}, 1'b0);
        queue_card(make_card(8, 19, 1'b1), 1'b0);
        queue_card(make_card(34, 15, 1'b1), 1'b0);
        queue_card(make_card(37, 15, 1'b1), 1'b0);
        queue_card(make_card(34, 15, 1'b0), 1'b0);
        queue_card(make_card(35, 15, 1'b1), 1'b0);
        queue_card(make_card(37, 16, 1'b1), 1'b0);
        queue_card(make_card(51, 16, 1'b1), 1'b0);
        queue_card(make_card(55, 16, 1'b1), 1'b0);
        queue_card(make_card(53, 16, 1'b0), 1'b0);
        queue_card(make_card(50, 16, 1'b1), 1'b0);
        queue_card(make_card(56, 16, 1'b1), 1'b0);
        queue_card(make_card(51, 15, 1'b1), 1'b0);
        queue_card(make_card(4, 13, 1'b1), 1'b0);
        queue_card(make_card(4, 13, 1'b0), 1'b0);
        queue_card(make_card(4, 16, 1'b1), 1'b0);
        queue_card(make_card(4, 14, 1'b1), 1'b0);
        queue_card(make_card(4, 15, 1'b1), 1'b0);

        // Random: mostly well-formed brand numbers, then broken check digits,
        // near misses, raw words of every length and Luhn-good numbers of
        // random length. Pause twice until the block has drained.
        for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin : fill
            int unsigned pick;
            int unsigned ndig;
            logic [IN_WIDTH-1:0] num;
            pick = $urandom_range(0, 99);
            ndig = $urandom_range(2, 19);
            if (pick < 45)
                num = brand_card(1'b1);
            else if (pick < 60)
                num = brand_card(1'b0);
            else if (pick < 75)
                num = make_card($urandom_range(10, 99), $urandom_range(12, 17), 1'b1);
            else if (pick < 95)
                num = raw_card();
            else
                num = make_card($urandom_range(1, (ndig == 19) ? 8 : 9), ndig, 1'b1);
            queue_card(num, i == 0 || i == 700);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (cards_pending.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d words and %0d verdicts, %0d of them passing Luhn.",
                 words_accepted, results_taken, luhn_passes);
        $display("Brands seen: none %0d, 34/37 %0d, 51-55 %0d, 4 %0d; %0d faults.",
                 brand_tally[0], brand_tally[1], brand_tally[2], brand_tally[3], faults);
        if (faults == 0 && verdicts_due.size() == 0) begin
            $display("tb_luhn_card_brand_check: PASS");
        end else begin
            $display("tb_luhn_card_brand_check: FAIL");
        end
        $finish;
    end

    // Watchdog: several times the slowest correct run.
    initial begin
        #4000000;
        $display("Timeout with %0d verdicts still due.", verdicts_due.size());
        $display("tb_luhn_card_brand_check: FAIL");
        $finish;
    end

endmodule

>>> luhn_card_brand_check.f
sv/lcb_pkg.sv
sv/lcb_digit_cell.sv
sv/lcb_digit_scan.sv
sv/luhn_card_brand_check.sv
tb/sv/tb_luhn_card_brand_check.sv
